@@ src/crc16_poly8005_byte_stream_unit_macros.svh @@
// assertion macros used by the checker of the crc byte stream unit
`ifndef CRC16_POLY8005_BYTE_STREAM_UNIT_MACROS_SVH
`define CRC16_POLY8005_BYTE_STREAM_UNIT_MACROS_SVH

// condition and consequence in the same cycle
`define CBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define CBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/crc16bs_pkg.sv @@
package crc16bs_pkg;

    localparam int unsigned CRC_W  = 16;
    localparam int unsigned BYTE_W = 8;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8005;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic             valid;
        logic [CRC_W-1:0] crc;
    } t_result;

    // eight bit steps, data lsb first
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  start,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] acc;
        logic             fb;
        acc = start;
        for (int k = 0; k < BYTE_W; k++) begin
            fb  = acc[CRC_W-1] ^ data[k];
            acc = {acc[CRC_W-2:0], 1'b0};
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

endpackage

@@ src/crc16bs_in_stage.sv @@
module crc16bs_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  crc16bs_pkg::t_in_item i_item,
    input  logic                  i_advance,
    output logic                  o_valid,
    output crc16bs_pkg::t_in_item o_item
);

    logic                  r_valid;
    logic                  n_valid;
    crc16bs_pkg::t_in_item r_item;
    logic                  accept;

    // the held byte leaves in the same cycle a new one arrives
    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ src/crc16bs_core.sv @@
module crc16bs_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [crc16bs_pkg::CRC_W-1:0]       i_cfg_wr_data,
    input  logic                                i_valid,
    input  crc16bs_pkg::t_in_item               i_item,
    input  logic                                i_out_free,
    output logic                                o_advance,
    output crc16bs_pkg::t_result                o_result
);

    logic [crc16bs_pkg::CRC_W-1:0] r_seed;
    logic [crc16bs_pkg::CRC_W-1:0] r_crc;
    logic [crc16bs_pkg::CRC_W-1:0] n_crc;
    logic                          r_mid;
    logic                          n_mid;
    logic [crc16bs_pkg::CRC_W-1:0] start;

    // only a last byte needs room in the result register
    assign o_advance = i_valid && (!i_item.last || i_out_free);
    assign start     = r_mid ? r_crc : r_seed;

    always_comb begin
        n_crc = r_crc;
        n_mid = r_mid;
        if (o_advance) begin
            n_crc = crc16bs_pkg::crc_byte(start, i_item.data);
            n_mid = !i_item.last;
        end
    end

    assign o_result.valid = o_advance && i_item.last;
    assign o_result.crc   = n_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_crc  <= '0;
            r_mid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
            r_crc <= n_crc;
            r_mid <= n_mid;
        end
    end

endmodule

@@ src/crc16bs_out_stage.sv @@
module crc16bs_out_stage (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  crc16bs_pkg::t_result               i_result,
    output logic                               o_free,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [crc16bs_pkg::BYTE_W-1:0]     o_crc_low,
    output logic [crc16bs_pkg::BYTE_W-1:0]     o_crc_high
);

    logic                          r_valid;
    logic                          n_valid;
    logic [crc16bs_pkg::CRC_W-1:0] r_crc;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_result.valid) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_crc <= i_result.crc;
        end
    end

    assign o_valid    = r_valid;
    assign o_crc_low  = r_crc[crc16bs_pkg::BYTE_W-1:0];
    assign o_crc_high = r_crc[crc16bs_pkg::CRC_W-1:crc16bs_pkg::BYTE_W];

endmodule

@@ src/crc16_poly8005_byte_stream_unit.sv @@
// CRC-16 (polynomial 0x8005) over a byte stream, data bits taken lsb first.
// One byte is accepted per clock unless a last byte waits on a stalled
// output; each transfer passes an input register, then the eight unrolled
// bit steps update the running CRC. A byte flagged last gives one result
// transfer (crc low and high bytes) through the output register; other
// bytes give none. Throughput is one byte per cycle under the same
// condition, set by the byte-wide update of the CRC register. The seed
// register is loaded into the CRC at the first byte of each message and
// takes effect from the next message when written.
module crc16_poly8005_byte_stream_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_crc_low,
    output logic [7:0]  o_crc_high
);

    crc16bs_pkg::t_in_item in_item;
    crc16bs_pkg::t_in_item held_item;
    crc16bs_pkg::t_result  result;
    logic                  held_valid;
    logic                  advance;
    logic                  out_free;

    assign in_item.data = i_data_byte;
    assign in_item.last = i_last_byte;

    crc16bs_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    crc16bs_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (held_valid),
        .i_item        (held_item),
        .i_out_free    (out_free),
        .o_advance     (advance),
        .o_result      (result)
    );

    crc16bs_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_result   (result),
        .o_free     (out_free),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_crc_low  (o_crc_low),
        .o_crc_high (o_crc_high)
    );

endmodule

@@ src/crc16bs_checker.sv @@
`include "crc16_poly8005_byte_stream_unit_macros.svh"

module crc16bs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_last_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_crc_low,
    input logic [7:0] o_crc_high
);

    // stalled result holds
    `CBS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_crc_low) && $stable(o_crc_high), "stalled result changed")

    // nothing comes out straight after reset
    `CBS_ASSERT_NOW(a_out_after_rst, $rose(i_rst_n), !o_out_valid, "result valid after reset")

    // a fresh result must be preceded by a last-byte input transfer
    `CBS_ASSERT_NOW(a_out_source, $rose(o_out_valid), $past(i_in_valid && !o_in_stall && i_last_byte, 2), "result without a last-byte transfer")

    // input only backs up behind a waiting result
    `CBS_ASSERT_NOW(a_stall_cause, !o_out_valid, !o_in_stall, "input stalled with empty output")

endmodule

bind crc16_poly8005_byte_stream_unit crc16bs_checker u_crc16bs_checker (.*);
